/* design/mck_pkg.sv */
// Shared types, constants and the Morse code table of the keyer.
`default_nettype none
package mck_pkg;

    localparam int UNIT_W = 20;
    localparam int HALF_W = 16;
    localparam int DUR_W  = UNIT_W + 2;
    localparam int REM_W  = UNIT_W + 3;

    localparam logic [UNIT_W-1:0] UNIT_RESET = 20'd20000;
    localparam logic [HALF_W-1:0] HALF_RESET = 16'd400;

    // Configuration register indexes
    localparam logic CFG_UNIT_TICKS = 1'b0;
    localparam logic CFG_HALF_PERIOD = 1'b1;

    // Character codes
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Entry: length in [7:5], element bits in [4:0], dash is one, first element in bit 0
    localparam logic [7:0] LETTER_ROM [26] = '{
        8'h42, 8'h81, 8'h85, 8'h61, 8'h20, 8'h84, 8'h63, 8'h80,
        8'h40, 8'h8E, 8'h65, 8'h82, 8'h43, 8'h41, 8'h67, 8'h86,
        8'h8B, 8'h62, 8'h60, 8'h21, 8'h64, 8'h88, 8'h66, 8'h89,
        8'h8D, 8'h83
    };

    // Zero is keyed as five dashes
    localparam logic [7:0] DIGIT_ROM [10] = '{
        8'hBF, 8'hBE, 8'hBC, 8'hB8, 8'hB0, 8'hA0, 8'hA1, 8'hA3,
        8'hA7, 8'hAF
    };

    typedef struct packed {
        logic       found;
        logic       space;
        logic [2:0] len;
        logic [4:0] bits;
    } t_sym;

    typedef struct packed {
        logic tone_pin;
        logic busy_res;
        logic accepted;
    } t_result;

endpackage
`default_nettype wire

/* design/mck_lookup.sv */
// Character decoder: Morse table lookup for letters and digits, space detect.
`default_nettype none
module mck_lookup
    import mck_pkg::*;
(
    input  wire logic [7:0] i_char_code,
    output t_sym            o_sym
);

    logic [7:0] lower_off;
    logic [7:0] upper_off;
    logic [7:0] digit_off;
    logic [7:0] entry;

    assign lower_off = i_char_code - CH_LOWER_A;
    assign upper_off = i_char_code - CH_UPPER_A;
    assign digit_off = i_char_code - CH_ZERO;

    always_comb begin
        o_sym       = '0;
        entry       = '0;
        o_sym.space = (i_char_code == CH_SPACE);
        if (i_char_code >= CH_LOWER_A && i_char_code <= CH_LOWER_Z) begin
            entry       = LETTER_ROM[lower_off[4:0]];
            o_sym.found = 1'b1;
        end else if (i_char_code >= CH_UPPER_A && i_char_code <= CH_UPPER_Z) begin
            entry       = LETTER_ROM[upper_off[4:0]];
            o_sym.found = 1'b1;
        end else if (i_char_code >= CH_ZERO && i_char_code <= CH_NINE) begin
            entry       = DIGIT_ROM[digit_off[3:0]];
            o_sym.found = 1'b1;
        end
        o_sym.len  = entry[7:5];
        o_sym.bits = entry[4:0];
    end

endmodule
`default_nettype wire

/* design/mck_sequencer.sv */
// Keying state machine: element timing, tone pin toggling, request handling.
`default_nettype none
module mck_sequencer
    import mck_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_go,
    input  wire logic              i_action,
    input  wire t_sym              i_sym,
    input  wire logic [UNIT_W-1:0] i_unit_ticks,
    input  wire logic [HALF_W-1:0] i_tone_half_period,
    output t_result                o_res
);

    typedef enum logic [1:0] {PH_IDLE, PH_TONE, PH_GAP} t_phase;

    typedef struct packed {
        t_phase           ph;
        logic [4:0]       bits;
        logic [2:0]       left;
        logic [REM_W-1:0] rem;
    } t_load;

    t_phase            r_phase, n_phase;
    logic [4:0]        r_bits, n_bits;
    logic [2:0]        r_left, n_left;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [HALF_W-1:0] r_seg, n_seg;
    logic [HALF_W-1:0] r_hl, n_hl;
    logic [HALF_W-1:0] r_hc, n_hc;
    logic              r_pin, n_pin;

    logic [DUR_W-1:0]  unit1;
    logic [DUR_W-1:0]  unit3;
    logic [REM_W-1:0]  unit5;
    logic              unit_nz;
    logic              acc;
    logic              do_load;
    t_load             ld;
    logic [HALF_W-1:0] hc1;
    logic [HALF_W-1:0] seg1;
    logic [REM_W-1:0]  rem1;

    assign unit1   = {2'b00, i_unit_ticks};
    assign unit3   = {2'b00, i_unit_ticks} + {1'b0, i_unit_ticks, 1'b0};
    assign unit5   = {3'b000, i_unit_ticks} + {1'b0, i_unit_ticks, 2'b00};
    assign unit_nz = (i_unit_ticks != '0);

    // Start the next element: a tone if it holds at least one full half period,
    // otherwise its trailing gap; go idle when no element is left or units are zero.
    function automatic t_load f_load(input logic [4:0] b, input logic [2:0] l,
                                     input logic [DUR_W-1:0] u1,
                                     input logic [DUR_W-1:0] u3,
                                     input logic u_nz, input logic [HALF_W-1:0] h);
        t_load            r;
        logic [DUR_W-1:0] dur;
        r      = '0;
        r.ph   = PH_IDLE;
        dur    = b[0] ? u3 : u1;
        if (l != 3'd0 && u_nz) begin
            r.bits = b >> 1;
            r.left = l - 3'd1;
            if (h != '0 && dur >= {{(DUR_W-HALF_W){1'b0}}, h}) begin
                r.ph  = PH_TONE;
                r.rem = {1'b0, dur};
            end else begin
                r.ph  = PH_GAP;
                r.rem = (r.left == 3'd0) ? {1'b0, u3} : {1'b0, u1};
            end
        end
        return r;
    endfunction

    always_comb begin
        n_phase = r_phase;
        n_bits  = r_bits;
        n_left  = r_left;
        n_rem   = r_rem;
        n_seg   = r_seg;
        n_hl    = r_hl;
        n_hc    = r_hc;
        n_pin   = r_pin;
        acc     = 1'b0;
        do_load = 1'b0;
        hc1     = r_hc + 1'b1;
        seg1    = r_seg + 1'b1;
        rem1    = r_rem - 1'b1;
        if (i_go && !i_action && r_phase == PH_IDLE) begin
            ld = f_load(i_sym.bits, i_sym.len, unit1, unit3, unit_nz, i_tone_half_period);
        end else begin
            ld = f_load(r_bits, r_left, unit1, unit3, unit_nz, i_tone_half_period);
        end

        if (i_go) begin
            if (i_action) begin
                unique case (r_phase)
                    PH_TONE: begin
                        // toggle against the live half period
                        if (i_tone_half_period != '0 && hc1 >= i_tone_half_period) begin
                            n_pin = ~r_pin;
                            n_hc  = '0;
                        end else begin
                            n_hc  = hc1;
                        end
                        // length runs on the half period latched at load
                        n_rem = rem1;
                        n_seg = (seg1 == r_hl) ? '0 : seg1;
                        if (seg1 == r_hl && rem1 < {{(REM_W-HALF_W){1'b0}}, r_hl}) begin
                            if (unit_nz) begin
                                n_phase = PH_GAP;
                                n_rem   = (r_left == 3'd0) ? {1'b0, unit3} : {1'b0, unit1};
                            end else begin
                                n_phase = PH_IDLE;
                                n_rem   = '0;
                            end
                        end
                    end
                    PH_GAP: begin
                        n_rem = rem1;
                        if (rem1 == '0) begin
                            do_load = 1'b1;
                        end
                    end
                    PH_IDLE: begin
                        n_phase = PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end else if (r_phase == PH_IDLE) begin
                acc = 1'b1;
                if (i_sym.found) begin
                    do_load = 1'b1;
                end else if (i_sym.space) begin
                    n_bits = '0;
                    n_left = '0;
                    if (unit_nz) begin
                        n_phase = PH_GAP;
                        n_rem   = unit5;
                    end
                end
            end
        end

        if (do_load) begin
            n_phase = ld.ph;
            n_bits  = ld.bits;
            n_left  = ld.left;
            n_rem   = ld.rem;
            if (ld.ph == PH_TONE) begin
                n_seg = '0;
                n_hc  = '0;
                n_hl  = i_tone_half_period;
            end
        end

        o_res.tone_pin = n_pin;
        o_res.busy_res = (n_phase != PH_IDLE);
        o_res.accepted = acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bits  <= '0;
            r_left  <= '0;
            r_rem   <= '0;
            r_seg   <= '0;
            r_hl    <= '0;
            r_hc    <= '0;
            r_pin   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_bits  <= n_bits;
            r_left  <= n_left;
            r_rem   <= n_rem;
            r_seg   <= n_seg;
            r_hl    <= n_hl;
            r_hc    <= n_hc;
            r_pin   <= n_pin;
        end
    end

    a_tone_half_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_TONE |-> r_hl != '0)
        else $error("tone running with zero latched half period");

    a_seg_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_TONE |-> r_seg < r_hl)
        else $error("segment counter past latched half period");

    a_gap_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_GAP |-> r_rem != '0)
        else $error("gap phase with no ticks left");

    a_drop_keeps_pin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && !i_action && r_phase != PH_IDLE) |=> $stable(r_pin))
        else $error("dropped character changed the pin");

endmodule
`default_nettype wire

/* design/morse_code_keyer_unit.sv */
// Top level of the Morse keyer: request register, sequencer, result register.
// A request passes through the request register and then the result register before it shows on o_valid.
// Throughput: one request per cycle while results are taken; each request is a single pass through the
// decoder and the sequencer's next-state logic between two registers.
// While a result waits untaken, the request register still takes one request, then holds it.
// Reset (i_rst_n low, synchronous): both stages empty, keyer idle, sequencer pin low,
// unit_ticks 20000, tone_half_period 400.
`default_nettype none
module morse_code_keyer_unit
    import mck_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request channel
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_action,
    input  wire logic [7:0]        i_char_code,
    // result channel
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_tone_pin,
    output logic                   o_busy_res,
    output logic                   o_accepted,
    // configuration write port
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [UNIT_W-1:0] i_cfg_wdata
);

    // configuration registers
    logic [UNIT_W-1:0] r_unit_ticks;
    logic [HALF_W-1:0] r_half_period;

    // request stage
    logic              r_in_v;
    logic              r_action;
    logic [7:0]        r_char;

    // result stage
    logic              r_out_v;
    t_result           r_res;

    logic              go;
    t_sym              sym;
    t_result           res;

    // Process the held request when the result register is empty or being drained.
    assign go      = r_in_v && (!r_out_v || i_ready);
    assign o_ready = !r_in_v || go;

    assign o_valid    = r_out_v;
    assign o_tone_pin = r_res.tone_pin;
    assign o_busy_res = r_res.busy_res;
    assign o_accepted = r_res.accepted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks  <= UNIT_RESET;
            r_half_period <= HALF_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_UNIT_TICKS:  r_unit_ticks  <= i_cfg_wdata;
                CFG_HALF_PERIOD: r_half_period <= i_cfg_wdata[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    // Request register: hold until the sequencer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_ready) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_action <= i_action;
            r_char   <= i_char_code;
        end
    end

    // Result register: load on each processed request, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (go) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_res <= res;
        end
    end

    mck_lookup u_lookup (
        .i_char_code (r_char),
        .o_sym       (sym)
    );

    mck_sequencer u_sequencer (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_go               (go),
        .i_action           (r_action),
        .i_sym              (sym),
        .i_unit_ticks       (r_unit_ticks),
        .i_tone_half_period (r_half_period),
        .o_res              (res)
    );

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_ready) |=> r_out_v && $stable(r_res))
        else $error("stalled result changed");

    a_go_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |-> (!r_out_v || i_ready))
        else $error("result overwritten before it was taken");

    a_req_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && !go) |=> r_in_v && $stable(r_char) && $stable(r_action))
        else $error("pending request lost");

endmodule
`default_nettype wire
